// ----- src/mpst_pkg.sv -----
// Package: shared widths, operation codes, arithmetic unit types and the result type for the pair sum unit.
`default_nettype none
package mpst_pkg;

	localparam int VAL_W         = 20;
	localparam int SUM_W         = VAL_W + 1;
	localparam int DEF_MAX_ITEMS = 1024;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef struct packed {
		logic [VAL_W-1:0] a;
		logic [VAL_W-1:0] b;
		logic [VAL_W-1:0] limit;
		logic [VAL_W-1:0] best;
	} alu_req_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic             le;
		logic             eq;
		logic             gt;
	} alu_rsp_t;

	typedef struct packed {
		logic             valid;
		logic [VAL_W-1:0] data;
	} res_t;

endpackage
`default_nettype wire

// ----- src/mpst_mem.sv -----
// Price memory: one write port, two read ports with registered read data.
`default_nettype none
module mpst_mem #(
	parameter int DEPTH = mpst_pkg::DEF_MAX_ITEMS,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic                    clk,
	input  wire logic                    we,
	input  wire logic [AW-1:0]           waddr,
	input  wire logic [mpst_pkg::VAL_W-1:0] wdata,
	input  wire logic [AW-1:0]           raddr_a,
	input  wire logic [AW-1:0]           raddr_b,
	output logic      [mpst_pkg::VAL_W-1:0] rdata_a,
	output logic      [mpst_pkg::VAL_W-1:0] rdata_b
);
	import mpst_pkg::*;

	logic [VAL_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule
`default_nettype wire

// ----- src/mpst_alu.sv -----
// Shared add and compare unit: pair sum against the target and the running best.
`default_nettype none
module mpst_alu (
	input  wire mpst_pkg::alu_req_t req,
	output mpst_pkg::alu_rsp_t      rsp
);
	import mpst_pkg::*;

	logic [SUM_W-1:0] sum;

	assign sum     = {1'b0, req.a} + {1'b0, req.b};
	assign rsp.sum = sum;
	assign rsp.le  = sum <= {1'b0, req.limit};
	assign rsp.eq  = sum == {1'b0, req.limit};
	assign rsp.gt  = sum > {1'b0, req.best};

endmodule
`default_nettype wire

// ----- src/mpst_seq.sv -----
// Sequencer: sorted insertion of loads and two-pointer search for queries.
`default_nettype none
module mpst_seq #(
	parameter int MAX_ITEMS = mpst_pkg::DEF_MAX_ITEMS,
	parameter int AW        = $clog2(MAX_ITEMS),
	parameter int CW        = $clog2(MAX_ITEMS + 1)
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	input  wire logic                       operation,
	input  wire logic [mpst_pkg::VAL_W-1:0] value,
	output logic                            in_stall,
	input  wire logic                       out_free,
	output mpst_pkg::res_t                  res,
	output logic                            mem_we,
	output logic      [AW-1:0]              mem_waddr,
	output logic      [mpst_pkg::VAL_W-1:0] mem_wdata,
	output logic      [AW-1:0]              mem_raddr_a,
	output logic      [AW-1:0]              mem_raddr_b,
	input  wire logic [mpst_pkg::VAL_W-1:0] mem_rdata_a,
	input  wire logic [mpst_pkg::VAL_W-1:0] mem_rdata_b,
	output mpst_pkg::alu_req_t              alu_req,
	input  wire mpst_pkg::alu_rsp_t         alu_rsp
);
	import mpst_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INS,
		ST_QRY,
		ST_RES
	} state_t;

	state_t           state_q;
	logic [CW-1:0]    cnt_q;
	logic [AW-1:0]    pos_q;
	logic [AW-1:0]    lo_q;
	logic [AW-1:0]    hi_q;
	logic [VAL_W-1:0] v_q;
	logic [VAL_W-1:0] best_q;

	logic [CW-1:0] cnt_dec;
	logic [AW-1:0] cnt_m1;
	logic          full;
	logic          ins_done;
	logic [AW-1:0] lo_n;
	logic [AW-1:0] hi_n;
	logic          qry_done;

	assign cnt_dec  = cnt_q - CW'(1);
	assign cnt_m1   = cnt_dec[AW-1:0];
	assign full     = cnt_q == CW'(MAX_ITEMS);
	assign in_stall = state_q != ST_IDLE;

	assign alu_req.a     = mem_rdata_a;
	assign alu_req.b     = (state_q == ST_QRY) ? mem_rdata_b : '0;
	assign alu_req.limit = v_q;
	assign alu_req.best  = best_q;

	assign ins_done = (pos_q == '0) || alu_rsp.le;
	assign lo_n     = alu_rsp.le ? lo_q + AW'(1) : lo_q;
	assign hi_n     = alu_rsp.le ? hi_q : hi_q - AW'(1);
	assign qry_done = (alu_rsp.le && alu_rsp.eq) || (lo_n >= hi_n);

	always_comb begin
		mem_we      = 1'b0;
		mem_waddr   = pos_q;
		mem_wdata   = v_q;
		mem_raddr_a = lo_n;
		mem_raddr_b = hi_n;
		unique case (state_q)
			ST_IDLE: begin
				mem_raddr_a = (operation == OP_LOAD) ? cnt_m1 : '0;
				mem_raddr_b = cnt_m1;
				if (in_valid && operation == OP_LOAD && !full && cnt_q == '0) begin
					mem_we    = 1'b1;
					mem_waddr = '0;
					mem_wdata = value;
				end
			end
			ST_INS: begin
				mem_we      = 1'b1;
				mem_raddr_a = pos_q - AW'(2);
				if (!ins_done) begin
					mem_wdata = mem_rdata_a;
				end
			end
			ST_QRY: begin
			end
			ST_RES: begin
				mem_raddr_a = lo_q;
				mem_raddr_b = hi_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			res.valid <= 1'b0;
		end else begin
			res.valid <= (state_q == ST_RES) && out_free;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (operation == OP_LOAD) begin
							if (!full) begin
								if (cnt_q == '0) begin
									cnt_q <= cnt_q + CW'(1);
								end else begin
									v_q     <= value;
									pos_q   <= cnt_q[AW-1:0];
									state_q <= ST_INS;
								end
							end
						end else begin
							v_q     <= value;
							best_q  <= '0;
							lo_q    <= '0;
							hi_q    <= cnt_m1;
							state_q <= (cnt_q < CW'(2)) ? ST_RES : ST_QRY;
						end
					end
				end
				ST_INS: begin
					if (ins_done) begin
						cnt_q   <= cnt_q + CW'(1);
						state_q <= ST_IDLE;
					end else begin
						pos_q <= pos_q - AW'(1);
					end
				end
				ST_QRY: begin
					if (alu_rsp.le && alu_rsp.gt) begin
						best_q <= alu_rsp.sum[VAL_W-1:0];
					end
					lo_q <= lo_n;
					hi_q <= hi_n;
					if (qry_done) begin
						state_q <= ST_RES;
					end
				end
				ST_RES: begin
					if (out_free) begin
						res.data <= best_q;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_ITEMS))
		else $error("item count above capacity");
	a_ptr_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_QRY |-> lo_q < hi_q)
		else $error("search pointers crossed");
	a_best_le_target: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_QRY || state_q == ST_RES |-> best_q <= v_q)
		else $error("best sum above target");
	a_ins_pos: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_INS |-> CW'(pos_q) <= cnt_q)
		else $error("insert position outside list");
	a_res_free: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> $past(out_free))
		else $error("result pushed into a full output register");
`endif

endmodule
`default_nettype wire

// ----- src/max_pair_sum_under_target_unit.sv -----
// Top level: pair sum search unit with price memory, sequencer and output register.
// Load: a value into an empty list is written directly at address zero; otherwise the sorted insert
//   shifts one entry per cycle through the price memory's write port.
// Query: one two-pointer step per cycle on the shared adder; the best sum then passes through the result
//   state, the sequencer's result register and the output register. A query on fewer than two prices skips the search.
// Reset clears the item count and output valid; the price memory is not cleared.
`default_nettype none
module max_pair_sum_under_target_unit #(
	parameter int MAX_ITEMS = mpst_pkg::DEF_MAX_ITEMS
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic                       operation,
	input  wire logic [mpst_pkg::VAL_W-1:0] value,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic      [mpst_pkg::VAL_W-1:0] best_sum
);
	import mpst_pkg::*;

	localparam int AW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);

	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [VAL_W-1:0] mem_wdata;
	logic [AW-1:0]    mem_raddr_a;
	logic [AW-1:0]    mem_raddr_b;
	logic [VAL_W-1:0] mem_rdata_a;
	logic [VAL_W-1:0] mem_rdata_b;
	alu_req_t         alu_req;
	alu_rsp_t         alu_rsp;
	res_t             res;
	logic             out_free;
	logic             out_valid_q;
	logic [VAL_W-1:0] best_sum_q;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign best_sum  = best_sum_q;

	mpst_mem #(
		.DEPTH(MAX_ITEMS),
		.AW   (AW)
	) u_mem (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.raddr_a(mem_raddr_a),
		.raddr_b(mem_raddr_b),
		.rdata_a(mem_rdata_a),
		.rdata_b(mem_rdata_b)
	);

	mpst_alu u_alu (
		.req(alu_req),
		.rsp(alu_rsp)
	);

	mpst_seq #(
		.MAX_ITEMS(MAX_ITEMS),
		.AW       (AW),
		.CW       (CW)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.operation  (operation),
		.value      (value),
		.in_stall   (in_stall),
		.out_free   (out_free),
		.res        (res),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_raddr_a(mem_raddr_a),
		.mem_raddr_b(mem_raddr_b),
		.mem_rdata_a(mem_rdata_a),
		.mem_rdata_b(mem_rdata_b),
		.alu_req    (alu_req),
		.alu_rsp    (alu_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (res.valid) begin
				out_valid_q <= 1'b1;
				best_sum_q  <= res.data;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !res.valid)
		else $error("result lost in output register");
	a_busy_no_out_gap: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |=> out_valid_q && best_sum_q == $past(res.data))
		else $error("result not captured");
	a_res_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> $past(in_stall))
		else $error("result without a query in progress");
`endif

endmodule
`default_nettype wire
